@@ hw/rtl/ps2mpt_pkg.sv @@
package ps2mpt_pkg;

    // Width of one byte from the controller
    localparam int BYTE_W = 8;

    // Width of the configuration write data (widest register)
    localparam int CFG_W = 10;

    // Controller status bits that qualify a mouse byte
    localparam int STAT_OBF_BIT = 0;
    localparam int STAT_AUX_BIT = 5;

    // Byte that marks the button byte during alignment
    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h08;

    // Reset values of the bounds and of the cursor
    localparam int RST_MIN_X_VAL  = 1;
    localparam int RST_MAX_X_VAL  = 312;
    localparam int RST_MIN_Y_VAL  = 1;
    localparam int RST_MAX_Y_VAL  = 190;
    localparam int RST_CURSOR_VAL = 50;

    // Position of a byte within a packet
    typedef enum logic [1:0] {
        PHASE_FIRST  = 2'd0,
        PHASE_SECOND = 2'd1,
        PHASE_THIRD  = 2'd2
    } phase_t;

    // Field order lock
    typedef enum logic [1:0] {
        ALIGN_UNKNOWN = 2'd0,
        ALIGN_STD     = 2'd1,
        ALIGN_SHIFT   = 2'd2
    } align_t;

    // Kind of input item
    typedef enum logic {
        ACT_EVENT       = 1'b0,
        ACT_STATUS_READ = 1'b1
    } action_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MIN_X = 2'd0,
        CFG_MAX_X = 2'd1,
        CFG_MIN_Y = 2'd2,
        CFG_MAX_Y = 2'd3
    } cfg_idx_t;

    // Sticky button codes
    typedef enum logic [1:0] {
        BTN_NONE   = 2'd0,
        BTN_LEFT   = 2'd1,
        BTN_RIGHT  = 2'd2,
        BTN_MIDDLE = 2'd3
    } button_t;

    // One input item
    typedef struct packed {
        action_t           action;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] ctrl_status;
    } item_t;

    // The highest pressed button wins; with none pressed the code is kept.
    function automatic button_t take_buttons(logic [BYTE_W-1:0] b, button_t cur);
        button_t res;
        res = cur;
        if (b[0]) res = BTN_LEFT;
        if (b[1]) res = BTN_RIGHT;
        if (b[2]) res = BTN_MIDDLE;
        return res;
    endfunction

endpackage

@@ hw/rtl/ps2mpt_in_reg.sv @@
module ps2mpt_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ps2mpt_pkg::item_t s_item,
    input  logic              advance,
    output logic              item_valid,
    output ps2mpt_pkg::item_t item
);
    import ps2mpt_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    // The register takes a new item when empty or when its item moves on
    assign s_tready = !valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload holds no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ hw/rtl/ps2mpt_tracker.sv @@
module ps2mpt_tracker #(
    parameter int POS_BITS = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  ps2mpt_pkg::cfg_idx_t       cfg_addr,
    input  logic [ps2mpt_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                       advance,
    input  ps2mpt_pkg::item_t          item,
    output logic [POS_BITS-1:0]        res_pos_x,
    output logic [POS_BITS-1:0]        res_pos_y,
    output ps2mpt_pkg::button_t        res_button,
    output logic                       res_done
);
    import ps2mpt_pkg::*;

    localparam int SW = POS_BITS + 2;

    localparam logic [POS_BITS-1:0] RST_MIN_X  = POS_BITS'(RST_MIN_X_VAL);
    localparam logic [POS_BITS-1:0] RST_MAX_X  = POS_BITS'(RST_MAX_X_VAL);
    localparam logic [POS_BITS-1:0] RST_MIN_Y  = POS_BITS'(RST_MIN_Y_VAL);
    localparam logic [POS_BITS-1:0] RST_MAX_Y  = POS_BITS'(RST_MAX_Y_VAL);
    localparam logic [POS_BITS-1:0] RST_CURSOR = POS_BITS'(RST_CURSOR_VAL);

    // Raise to the minimum first, then lower to the maximum
    function automatic logic [POS_BITS-1:0] clamp_pos(
        logic signed [SW-1:0] v,
        logic [POS_BITS-1:0]  lo,
        logic [POS_BITS-1:0]  hi
    );
        logic signed [SW-1:0] t;
        t = v;
        if (t < $signed({2'b00, lo})) t = $signed({2'b00, lo});
        if (t > $signed({2'b00, hi})) t = $signed({2'b00, hi});
        return t[POS_BITS-1:0];
    endfunction

    logic [POS_BITS-1:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic [POS_BITS-1:0] cursor_x_reg, cursor_x_next;
    logic [POS_BITS-1:0] cursor_y_reg, cursor_y_next;
    logic [BYTE_W-1:0]   first_reg, first_next;
    logic [BYTE_W-1:0]   second_reg, second_next;
    phase_t              phase_reg, phase_next;
    align_t              align_reg, align_next;
    button_t             button_reg, button_next;

    logic [CFG_W+POS_BITS-1:0] cfg_wide;
    logic [POS_BITS-1:0]       cfg_val;
    logic                      counted;
    logic                      done;
    align_t                    align_eff;
    logic [BYTE_W-1:0]         dx;
    logic signed [SW-1:0]      x_pre;
    logic signed [SW-1:0]      y_pre;

    // Configuration data trimmed or widened to the position width
    assign cfg_wide = {{POS_BITS{1'b0}}, cfg_wdata};
    assign cfg_val  = cfg_wide[POS_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg <= RST_MIN_X;
            max_x_reg <= RST_MAX_X;
            min_y_reg <= RST_MIN_Y;
            max_y_reg <= RST_MAX_Y;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_MIN_X: min_x_reg <= cfg_val;
                CFG_MAX_X: max_x_reg <= cfg_val;
                CFG_MIN_Y: min_y_reg <= cfg_val;
                CFG_MAX_Y: max_y_reg <= cfg_val;
                default:   min_x_reg <= min_x_reg;
            endcase
        end
    end

    // A byte counts only when output full and auxiliary are both set
    assign counted = (item.action == ACT_EVENT) && item.ctrl_status[STAT_OBF_BIT]
                     && item.ctrl_status[STAT_AUX_BIT];

    // Packet assembly, alignment lock, cursor and button update
    always_comb
    begin
        phase_next  = phase_reg;
        first_next  = first_reg;
        second_next = second_reg;
        align_next  = align_reg;
        button_next = button_reg;
        done        = 1'b0;
        align_eff   = align_reg;
        dx          = first_reg;
        x_pre       = $signed({2'b00, cursor_x_reg});
        y_pre       = $signed({2'b00, cursor_y_reg});
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;

        if (item.action == ACT_STATUS_READ)
        begin
            button_next = BTN_NONE;
        end
        else
        begin
            if (counted)
            begin
                case (phase_reg)
                    PHASE_SECOND:
                    begin
                        second_next = item.data_byte;
                        phase_next  = PHASE_THIRD;
                    end
                    PHASE_THIRD:
                    begin
                        phase_next = PHASE_FIRST;
                        done       = 1'b1;
                        if (align_reg == ALIGN_UNKNOWN)
                        begin
                            if (first_reg == SYNC_BYTE)
                            begin
                                align_eff = ALIGN_STD;
                            end
                            else if (second_reg == SYNC_BYTE)
                            begin
                                align_eff = ALIGN_SHIFT;
                            end
                        end
                        align_next = align_eff;
                        if (align_eff != ALIGN_UNKNOWN)
                        begin
                            if (align_eff == ALIGN_STD)
                            begin
                                dx          = second_reg;
                                button_next = take_buttons(first_reg, button_reg);
                            end
                            else
                            begin
                                dx          = first_reg;
                                button_next = take_buttons(second_reg, button_reg);
                            end
                            x_pre = $signed({2'b00, cursor_x_reg})
                                    + $signed({{(SW-BYTE_W){dx[BYTE_W-1]}}, dx});
                            y_pre = $signed({2'b00, cursor_y_reg})
                                    + $signed({{(SW-BYTE_W){item.data_byte[BYTE_W-1]}},
                                               item.data_byte});
                        end
                    end
                    default:
                    begin
                        first_next = item.data_byte;
                        phase_next = PHASE_SECOND;
                    end
                endcase
            end
            // Every controller event clamps the cursor
            cursor_x_next = clamp_pos(x_pre, min_x_reg, max_x_reg);
            cursor_y_next = clamp_pos(y_pre, min_y_reg, max_y_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PHASE_FIRST;
            first_reg    <= '0;
            second_reg   <= '0;
            align_reg    <= ALIGN_UNKNOWN;
            cursor_x_reg <= RST_CURSOR;
            cursor_y_reg <= RST_CURSOR;
            button_reg   <= BTN_NONE;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            first_reg    <= first_next;
            second_reg   <= second_next;
            align_reg    <= align_next;
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            button_reg   <= button_next;
        end
    end

    // A status read reports the button code from before the clear
    assign res_pos_x  = cursor_x_next;
    assign res_pos_y  = cursor_y_next;
    assign res_button = (item.action == ACT_STATUS_READ) ? button_reg : button_next;
    assign res_done   = done;

endmodule

@@ hw/rtl/ps2mpt_out_reg.sv @@
module ps2mpt_out_reg #(
    parameter int WIDTH = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic [WIDTH-1:0] load_data,
    output logic             can_load,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [WIDTH-1:0] m_tdata
);

    logic             valid_reg;
    logic             valid_next;
    logic [WIDTH-1:0] data_reg;

    // A new result may enter when the register is empty or is being taken
    assign can_load = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

@@ hw/rtl/ps2_mouse_packet_tracker_core.sv @@
// Channel  | Direction | Transfer on          | Contents
// s_*      | in        | s_tvalid & s_tready  | one controller event or status read
// m_*      | out       | m_tvalid & m_tready  | cursor, button code, packet flag
// cfg_*    | in        | cfg_we               | bound registers, no read-back
//
// Each transfer in gives exactly one transfer out, via the input register, then the result register.
// One item per cycle is sustained while m_tready stays high: the input register and
// the result register each take a new item while the one ahead moves on in the same cycle.
// The tracker state updates in the single cycle in which an item passes from the
// input register to the result register.
// Reset clears all control state and loads the bound and cursor reset values.
// A stall on m_tready backs up through both registers to s_tready.
module ps2_mouse_packet_tracker_core #(
    parameter int POS_BITS = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // s_tdata: ctrl_status [7:0], data_byte [15:8]
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [15:0]                  s_tdata,
    // s_tuser: action [0]
    input  logic                         s_tuser,
    // m_tdata: pos_x, pos_y, button_code (2), packet_done (1), zero padding
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [((2*POS_BITS+3+7)/8)*8-1:0] m_tdata,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_addr,
    input  logic [ps2mpt_pkg::CFG_W-1:0] cfg_wdata
);
    import ps2mpt_pkg::*;

    localparam int RES_W = 2 * POS_BITS + 3;
    localparam int OUT_W = ((RES_W + 7) / 8) * 8;

    item_t               s_item;
    item_t               item;
    logic                item_valid;
    logic                can_load;
    logic                advance;
    logic [POS_BITS-1:0] res_pos_x;
    logic [POS_BITS-1:0] res_pos_y;
    button_t             res_button;
    logic                res_done;
    logic [OUT_W-1:0]    res_data;

    // Unpack the incoming transfer
    assign s_item = '{action:      action_t'(s_tuser),
                      data_byte:   s_tdata[15:8],
                      ctrl_status: s_tdata[7:0]};

    assign advance = item_valid && can_load;

    ps2mpt_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ps2mpt_tracker #(
        .POS_BITS (POS_BITS)
    ) u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_idx_t'(cfg_addr)),
        .cfg_wdata  (cfg_wdata),
        .advance    (advance),
        .item       (item),
        .res_pos_x  (res_pos_x),
        .res_pos_y  (res_pos_y),
        .res_button (res_button),
        .res_done   (res_done)
    );

    // Pack the result with zero padding in the top bits
    assign res_data = OUT_W'({res_done, res_button, res_pos_y, res_pos_x});

    ps2mpt_out_reg #(
        .WIDTH (OUT_W)
    ) u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .load_data (res_data),
        .can_load  (can_load),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

@@ hw/rtl/ps2mpt_checker.sv @@
module ps2mpt_checker #(
    parameter int POS_BITS = 10
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [((2*POS_BITS+3+7)/8)*8-1:0] m_tdata
);

    localparam int DONE_BIT = 2 * POS_BITS + 2;

    logic last_done_reg;

    // Packet flag of the last result transferred out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_done_reg <= 1'b0;
        end
        else if (m_tvalid && m_tready)
        begin
            last_done_reg <= m_tdata[DONE_BIT];
        end
    end

    // No result is offered while reset is held
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result offered during reset");

    // A stalled result holds its value
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // With the output side taking results, the input side never stalls
    a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output was ready");

    // A packet needs three counted bytes, so two results in a row cannot both end one
    a_done_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && last_done_reg |-> !m_tdata[DONE_BIT])
        else $error("two consecutive results completed a packet");

endmodule

bind ps2_mouse_packet_tracker_core ps2mpt_checker #(
    .POS_BITS (POS_BITS)
) u_ps2mpt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ verif/tb_ps2_mouse_packet_tracker_core.sv @@
`timescale 1ns / 1ps

module tb_ps2_mouse_packet_tracker_core;

    import ps2mpt_pkg::*;

    localparam int POS_W    = 10;
    localparam int REPORT_W = ((2*POS_W+3+7)/8)*8;

    // One result as it sits in m_tdata, lowest field last in the declaration.
    typedef struct packed {
        logic             done;
        button_t          btn;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] x;
    } cursor_report_t;

    // Tracks the cursor, the packet assembly and the sticky button code, and
    // holds the reports still owed by the block.
    class cursor_tracker_sb;
        logic [POS_W-1:0] lo_x, hi_x, lo_y, hi_y;
        phase_t           phase;
        logic [7:0]       byte_a, byte_b;
        align_t           lock;
        logic [POS_W-1:0] cur_x, cur_y;
        button_t          held_btn;
        cursor_report_t   expected_reports[$];
        int               failures;

        function new();
            lo_x     = POS_W'(RST_MIN_X_VAL);
            hi_x     = POS_W'(RST_MAX_X_VAL);
            lo_y     = POS_W'(RST_MIN_Y_VAL);
            hi_y     = POS_W'(RST_MAX_Y_VAL);
            phase    = PHASE_FIRST;
            byte_a   = '0;
            byte_b   = '0;
            lock     = ALIGN_UNKNOWN;
            cur_x    = POS_W'(RST_CURSOR_VAL);
            cur_y    = POS_W'(RST_CURSOR_VAL);
            held_btn = BTN_NONE;
            failures = 0;
        endfunction

        function void set_bound(cfg_idx_t idx, logic [POS_W-1:0] v);
            case (idx)
                CFG_MIN_X: lo_x = v;
                CFG_MAX_X: hi_x = v;
                CFG_MIN_Y: lo_y = v;
                CFG_MAX_Y: hi_y = v;
                default: ;
            endcase
        endfunction

        // The minimum is applied first, so an inverted window gives the maximum.
        static function logic [POS_W-1:0] fit_range(int v, logic [POS_W-1:0] lo,
                                                     logic [POS_W-1:0] hi);
            if (v < int'(lo))
                v = int'(lo);
            if (v > int'(hi))
                v = int'(hi);
            return v[POS_W-1:0];
        endfunction

        // The highest pressed button overrides; with none pressed the code stays.
        function void latch_buttons(logic [7:0] b);
            if (b[0])
                held_btn = BTN_LEFT;
            if (b[1])
                held_btn = BTN_RIGHT;
            if (b[2])
                held_btn = BTN_MIDDLE;
        endfunction

        // Works out the report for one accepted input transfer.
        function void note_event(action_t act, logic [7:0] st, logic [7:0] db);
            cursor_report_t r;
            int             nx;
            int             ny;
            logic           done;
            done = 1'b0;
            if (act == ACT_STATUS_READ)
            begin
                r = '{done: 1'b0, btn: held_btn, y: cur_y, x: cur_x};
                held_btn = BTN_NONE;
            end
            else
            begin
                if (st[STAT_OBF_BIT] && st[STAT_AUX_BIT])
                begin
                    case (phase)
                        PHASE_SECOND:
                        begin
                            byte_b = db;
                            phase  = PHASE_THIRD;
                        end
                        PHASE_THIRD:
                        begin
                            phase = PHASE_FIRST;
                            done  = 1'b1;
                            // The field order locks once, on the first packet with a sync byte.
                            if (lock == ALIGN_UNKNOWN)
                            begin
                                if (byte_a == SYNC_BYTE)
                                    lock = ALIGN_STD;
                                else if (byte_b == SYNC_BYTE)
                                    lock = ALIGN_SHIFT;
                            end
                            if (lock != ALIGN_UNKNOWN)
                            begin
                                if (lock == ALIGN_STD)
                                begin
                                    nx = int'(cur_x) + int'($signed(byte_b));
                                    latch_buttons(byte_a);
                                end
                                else
                                begin
                                    nx = int'(cur_x) + int'($signed(byte_a));
                                    latch_buttons(byte_b);
                                end
                                ny    = int'(cur_y) + int'($signed(db));
                                cur_x = fit_range(nx, lo_x, hi_x);
                                cur_y = fit_range(ny, lo_y, hi_y);
                            end
                        end
                        default:
                        begin
                            byte_a = db;
                            phase  = PHASE_SECOND;
                        end
                    endcase
                end
                // Every controller event re-applies the window, counted or not.
                cur_x = fit_range(int'(cur_x), lo_x, hi_x);
                cur_y = fit_range(int'(cur_y), lo_y, hi_y);
                r = '{done: done, btn: held_btn, y: cur_y, x: cur_x};
            end
            expected_reports.push_back(r);
        endfunction

        // Compares one output transfer with the oldest outstanding report.
        function void check_report(logic [REPORT_W-1:0] w);
            cursor_report_t got;
            cursor_report_t want;
            got = cursor_report_t'(w[2*POS_W+2:0]);
            if (expected_reports.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: x=%0d y=%0d btn=%0d done=%0d",
                             got.x, got.y, got.btn, got.done);
            end
            else
            begin
                want = expected_reports.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.btn !== want.btn ||
                    got.done !== want.done)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("mismatch x,y,btn,done: exp %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                 want.x, want.y, want.btn, want.done,
                                 got.x, got.y, got.btn, got.done);
                end
            end
        endfunction
    endclass

    localparam int IDLE_LIMIT  = 1000;
    localparam int PHASE_ITEMS = 140;
    localparam int PHASES      = 6;

    logic                clk       = 1'b0;
    logic                rst_n;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [15:0]         s_tdata   = '0;
    logic                s_tuser   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [REPORT_W-1:0] m_tdata;
    logic                cfg_we    = 1'b0;
    logic [1:0]          cfg_addr  = '0;
    logic [CFG_W-1:0]    cfg_wdata = '0;

    bit               calm        = 1'b0;
    bit               std_order   = 1'b1;
    int               idle_cycles = 0;
    cursor_tracker_sb tracker;

    ps2_mouse_packet_tracker_core #(
        .POS_BITS (POS_W)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Clock generation.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Observe register writes and transfers on both sides.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                tracker.set_bound(cfg_idx_t'(cfg_addr), cfg_wdata);
            if (s_tvalid && s_tready)
                tracker.note_event(action_t'(s_tuser), s_tdata[7:0], s_tdata[15:8]);
            if (m_tvalid && m_tready)
                tracker.check_report(m_tdata);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("ps2_mouse_packet_tracker_core regression: fail");
            $finish;
        end
    end

    // Receiver: stalls a random number of cycles ahead of each result.
    initial
    begin
        int stall;
        @(posedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // Presents one item after a random gap and holds it until the transfer.
    task automatic send_item(action_t act, logic [7:0] st, logic [7:0] db);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {db, st};
        s_tuser  <= act;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Status byte that qualifies the data as a mouse byte; other bits random.
    function automatic logic [7:0] mouse_status();
        logic [7:0] s;
        s = 8'($urandom);
        s[STAT_OBF_BIT] = 1'b1;
        s[STAT_AUX_BIT] = 1'b1;
        return s;
    endfunction

    task automatic send_byte(logic [7:0] db);
        send_item(ACT_EVENT, mouse_status(), db);
    endtask

    // One packet in the field order that the lock is expected to pick.
    task automatic send_motion(logic [7:0] btn_byte, logic [7:0] dx, logic [7:0] dy);
        if (std_order)
        begin
            send_byte(btn_byte);
            send_byte(dx);
        end
        else
        begin
            send_byte(dx);
            send_byte(btn_byte);
        end
        send_byte(dy);
    endtask

    task automatic cfg_put(cfg_idx_t idx, logic [CFG_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v;
        @(posedge clk);
    endtask

    task automatic write_bounds(logic [POS_W-1:0] lx, logic [POS_W-1:0] hx,
                                logic [POS_W-1:0] ly, logic [POS_W-1:0] hy);
        cfg_put(CFG_MIN_X, lx);
        cfg_put(CFG_MAX_X, hx);
        cfg_put(CFG_MIN_Y, ly);
        cfg_put(CFG_MAX_Y, hy);
        cfg_we <= 1'b0;
    endtask

    // Stops sending and waits for every outstanding report.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.expected_reports.size() != 0)
            @(posedge clk);
    endtask

    // Main sequence.
    initial
    begin
        int               p;
        int               n;
        int               pick;
        logic [7:0]       b;
        logic [POS_W-1:0] lx;
        logic [POS_W-1:0] ly;
        rst_n <= 1'b0;
        tracker = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A status read straight after reset reports the reset cursor.
        send_item(ACT_STATUS_READ, 8'h00, 8'h00);
        // Events lacking output-full or auxiliary status are not mouse bytes.
        send_item(ACT_EVENT, 8'h00, 8'hFF);
        send_item(ACT_EVENT, 8'h01, SYNC_BYTE);
        send_item(ACT_EVENT, 8'h20, SYNC_BYTE);
        send_item(ACT_EVENT, 8'hDE, 8'h55);
        // Without a sync byte in the first two places the packet is dropped.
        send_byte(8'h07);
        send_byte(8'h80);
        send_byte(8'h7F);
        // Noise between counted bytes leaves the packet assembly alone.
        send_byte(8'h00);
        send_item(ACT_EVENT, 8'h1E, SYNC_BYTE);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_item(ACT_STATUS_READ, 8'hFF, 8'hFF);

        // The locking packet decides the field order for the rest of the run.
        std_order = 1'($urandom_range(0, 1));
        if (std_order && $urandom_range(0, 1))
            send_motion(SYNC_BYTE, SYNC_BYTE, 8'h80);
        else
            send_motion(SYNC_BYTE, 8'h7F, 8'h80);
        send_motion(8'h07, 8'h7F, 8'h80);
        send_item(ACT_STATUS_READ, mouse_status(), 8'h00);
        send_motion(8'h01, 8'h80, 8'h7F);
        send_item(ACT_STATUS_READ, 8'h00, 8'h00);

        // Random traffic under a different window in each phase.
        for (p = 0; p < PHASES; p++)
        begin
            drain();
            case (p)
                0: write_bounds(10'd0, 10'd1023, 10'd0, 10'd1023);
                1: write_bounds(10'd1023, 10'd0, 10'd1023, 10'd0);
                2:
                begin
                    lx = POS_W'($urandom_range(0, 1023));
                    ly = POS_W'($urandom_range(0, 1023));
                    write_bounds(lx, lx, ly, ly);
                end
                3:
                begin
                    lx = POS_W'($urandom_range(0, 600));
                    ly = POS_W'($urandom_range(0, 600));
                    write_bounds(lx, POS_W'(lx + $urandom_range(0, 200)),
                                 ly, POS_W'(ly + $urandom_range(0, 200)));
                end
                4: write_bounds(POS_W'($urandom), POS_W'($urandom),
                                POS_W'($urandom), POS_W'($urandom));
                default: write_bounds(10'd1000, 10'd1023, 10'd1000, 10'd1023);
            endcase
            calm = (p == 2) || (p == 4);
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    b = 8'($urandom);
                    if ($urandom_range(0, 1))
                        b[2:0] = 3'b000;
                    send_motion(b, 8'($urandom), 8'($urandom));
                    n += 3;
                end
                else if (pick < 80)
                begin
                    send_item(ACT_STATUS_READ, 8'($urandom), 8'($urandom));
                    n++;
                end
                else if (pick < 92)
                begin
                    b = 8'($urandom);
                    if ($urandom_range(0, 1))
                        b[STAT_OBF_BIT] = 1'b0;
                    else
                        b[STAT_AUX_BIT] = 1'b0;
                    send_item(ACT_EVENT, b, 8'($urandom));
                    n++;
                end
                else
                begin
                    // A lone byte shifts the packet boundary.
                    send_byte(8'($urandom));
                    n++;
                end
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (tracker.failures == 0 && tracker.expected_reports.size() == 0)
            $display("ps2_mouse_packet_tracker_core regression: pass");
        else
            $display("ps2_mouse_packet_tracker_core regression: fail");
        $finish;
    end

endmodule
